// ----- sv/gji_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix inverse package
// Shared types, codes and fixed-point helpers for the Gauss-Jordan inverse.
// ----------------------------------------------------------------------------
package gji_pkg;

    localparam int DIM_DEF = 3;
    localparam int DW      = 32;
    localparam int MW      = 48;
    localparam logic signed [DW-1:0] QONE = 32'sh0001_0000;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SR_CLR,
        ST_SR_RD,
        ST_SR_END,
        ST_MARK,
        ST_SW_RD,
        ST_SW_W1,
        ST_SW_W2,
        ST_PV_RD,
        ST_PV_CHK,
        ST_DIV,
        ST_SC_ONE,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_RND,
        ST_SC_WR,
        ST_EL_F,
        ST_EL_Z,
        ST_EL_RD,
        ST_EL_MUL,
        ST_EL_RND,
        ST_EL_WR,
        ST_PASS_END,
        ST_UN_CHK,
        ST_UN_RD,
        ST_UN_W1,
        ST_UN_W2,
        ST_UN_NEXT,
        ST_OUT_RD,
        ST_OUT_SHOW
    } t_state;

    typedef enum logic [2:0] {
        WS_ELEM,
        WS_RDA,
        WS_RDB,
        WS_ZERO,
        WS_ONE,
        WS_PROD,
        WS_DIFF
    } t_wsel;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        t_wsel wr_sel;
        logic  srch_clr;
        logic  srch_en;
        logic  div_start;
        logic  fac_ld;
        logic  mul_en;
        logic  rnd_en;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic piv_zero;
    } t_stat;

    function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    function automatic logic signed [DW-1:0] sat_mag(input logic [MW-1:0] m, input logic neg);
        logic signed [DW-1:0] r;
        if (neg) begin
            if (m > MW'(64'h8000_0000)) r = 32'sh8000_0000;
            else r = -$signed(m[DW-1:0]);
        end else begin
            if (m > MW'(64'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
            else r = $signed(m[DW-1:0]);
        end
        return r;
    endfunction

endpackage

// ----- sv/gji_recip.sv -----
// ----------------------------------------------------------------------------
// Reciprocal unit
// Restoring division of 2^32 by the pivot magnitude, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gji_recip
    import gji_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_value,
    output logic                 o_done,
    output logic signed [DW-1:0] o_recip
);

    localparam int QW = DW + 1;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_div, n_div;
    logic          r_neg, n_neg;
    logic signed [DW-1:0] r_recip, n_recip;
    logic [QW-1:0] w_shift;
    logic          w_ge;

    assign w_shift = {r_rem[DW-1:0], (r_cnt == '0)};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_neg   = r_neg;
        n_recip = r_recip;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = '0;
            n_div  = mag32(i_value);
            n_neg  = i_value[DW-1];
        end else if (r_busy) begin
            n_rem = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
            n_quo = {r_quo[DW-1:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(QW - 1)) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_recip = sat_mag(MW'({r_quo[DW-1:0], w_ge}), r_neg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_div   <= n_div;
        r_neg   <= n_neg;
        r_recip <= n_recip;
    end

    assign o_done  = r_done;
    assign o_recip = r_recip;

endmodule

// ----- sv/gji_datapath.sv -----
// ----------------------------------------------------------------------------
// Inverse datapath
// Matrix store, pivot search, multiply-round-subtract path and reciprocal.
// ----------------------------------------------------------------------------
module gji_datapath
    import gji_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [$clog2(DIM*DIM)-1:0]    i_rd_addr_a,
    input  logic [$clog2(DIM*DIM)-1:0]    i_rd_addr_b,
    input  logic [$clog2(DIM*DIM)-1:0]    i_wr_addr,
    input  logic [$clog2(DIM)-1:0]        i_srch_row,
    input  logic [$clog2(DIM)-1:0]        i_srch_col,
    input  logic signed [DW-1:0]          i_element,
    input  logic                          i_singular,
    output t_stat                         o_stat,
    output logic [$clog2(DIM)-1:0]        o_prow,
    output logic [$clog2(DIM)-1:0]        o_pcol,
    output logic signed [DW-1:0]          o_inverse_element
);

    localparam int NELEM = DIM * DIM;
    localparam int IW    = $clog2(DIM);

    logic signed [DW-1:0] r_mem [NELEM];
    logic signed [DW-1:0] r_rda, r_rdb;
    logic signed [DW-1:0] r_fac;
    logic [2*DW-1:0]      r_prod;
    logic                 r_pneg;
    logic signed [DW-1:0] r_q;
    logic [DW-1:0]        r_big;
    logic [IW-1:0]        r_prow, r_pcol, r_tag_row, r_tag_col;
    logic                 r_tag_vld;
    logic signed [DW-1:0] w_wdata;
    logic signed [DW:0]   w_diff;
    logic signed [DW-1:0] w_diff_sat;
    logic                 w_div_done;
    logic signed [DW-1:0] w_recip;

    gji_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_value (r_rda),
        .o_done  (w_div_done),
        .o_recip (w_recip)
    );

    assign w_diff = {r_rdb[DW-1], r_rdb} - {r_q[DW-1], r_q};

    always_comb begin
        if (w_diff > 33'sh0_7FFF_FFFF) w_diff_sat = 32'sh7FFF_FFFF;
        else if (w_diff < -33'sh0_8000_0000) w_diff_sat = 32'sh8000_0000;
        else w_diff_sat = w_diff[DW-1:0];
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WS_ELEM: w_wdata = i_element;
            WS_RDA:  w_wdata = r_rda;
            WS_RDB:  w_wdata = r_rdb;
            WS_ZERO: w_wdata = '0;
            WS_ONE:  w_wdata = QONE;
            WS_PROD: w_wdata = r_q;
            WS_DIFF: w_wdata = w_diff_sat;
            default: w_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rda <= r_mem[i_rd_addr_a];
            r_rdb <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_fac <= w_recip;
        end else if (i_cmd.fac_ld) begin
            r_fac <= r_rda;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mag32(r_rda) * mag32(r_fac);
            r_pneg <= r_rda[DW-1] ^ r_fac[DW-1];
        end
        if (i_cmd.rnd_en) begin
            r_q <= sat_mag(MW'((r_prod + 64'h8000) >> 16), r_pneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= 1'b0;
            r_big     <= '0;
            r_prow    <= '0;
            r_pcol    <= '0;
        end else if (i_cmd.srch_clr) begin
            r_tag_vld <= 1'b0;
            r_big     <= '0;
            r_prow    <= '0;
            r_pcol    <= '0;
        end else begin
            r_tag_vld <= i_cmd.srch_en;
            if (r_tag_vld && (mag32(r_rda) >= r_big)) begin
                r_big  <= mag32(r_rda);
                r_prow <= r_tag_row;
                r_pcol <= r_tag_col;
            end
        end
        r_tag_row <= i_srch_row;
        r_tag_col <= i_srch_col;
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.piv_zero  = (r_rda == '0);
    assign o_prow           = r_prow;
    assign o_pcol           = r_pcol;
    assign o_inverse_element = i_singular ? '0 : r_rda;

endmodule

// ----- sv/gji_ctrl.sv -----
// ----------------------------------------------------------------------------
// Inverse controller
// Sequences loading, pivot passes, column unswapping and result delivery.
// ----------------------------------------------------------------------------
module gji_ctrl
    import gji_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_stall,
    input  t_stat                         i_stat,
    input  logic [$clog2(DIM)-1:0]        i_prow,
    input  logic [$clog2(DIM)-1:0]        i_pcol,
    output t_cmd                          o_cmd,
    output logic [$clog2(DIM*DIM)-1:0]    o_rd_addr_a,
    output logic [$clog2(DIM*DIM)-1:0]    o_rd_addr_b,
    output logic [$clog2(DIM*DIM)-1:0]    o_wr_addr,
    output logic [$clog2(DIM)-1:0]        o_srch_row,
    output logic [$clog2(DIM)-1:0]        o_srch_col,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic                          o_singular,
    output logic                          o_last
);

    localparam int NELEM = DIM * DIM;
    localparam int AW    = $clog2(NELEM);
    localparam int IW    = $clog2(DIM);
    localparam logic [AW-1:0] LAST_IDX = AW'(NELEM - 1);
    localparam logic [IW-1:0] LAST_RC  = IW'(DIM - 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_pass, n_pass;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic [DIM-1:0]  r_used, n_used;
    logic [IW-1:0]   r_rec_row [DIM];
    logic [IW-1:0]   n_rec_row [DIM];
    logic [IW-1:0]   r_rec_col [DIM];
    logic [IW-1:0]   n_rec_col [DIM];
    logic            r_sing, n_sing;
    logic [IW-1:0]   w_ua, w_ub;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(r) * AW'(DIM) + AW'(c);
    endfunction

    assign w_ua = r_rec_row[r_pass];
    assign w_ub = r_rec_col[r_pass];

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pass    = r_pass;
        n_j       = r_j;
        n_k       = r_k;
        n_used    = r_used;
        n_rec_row = r_rec_row;
        n_rec_col = r_rec_col;
        n_sing    = r_sing;
        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_pass  = '0;
                        n_used  = '0;
                        n_sing  = 1'b0;
                        n_state = ST_SR_CLR;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_SR_CLR: begin
                n_j     = '0;
                n_k     = '0;
                n_state = ST_SR_RD;
            end
            ST_SR_RD: begin
                if (r_k == LAST_RC) begin
                    n_k = '0;
                    if (r_j == LAST_RC) n_state = ST_SR_END;
                    else n_j = r_j + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_SR_END: n_state = ST_MARK;
            ST_MARK: begin
                n_used[i_pcol]    = 1'b1;
                n_rec_row[r_pass] = i_prow;
                n_rec_col[r_pass] = i_pcol;
                n_k               = '0;
                n_state           = (i_prow != i_pcol) ? ST_SW_RD : ST_PV_RD;
            end
            ST_SW_RD: n_state = ST_SW_W1;
            ST_SW_W1: n_state = ST_SW_W2;
            ST_SW_W2: begin
                if (r_k == LAST_RC) begin
                    n_state = ST_PV_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_SW_RD;
                end
            end
            ST_PV_RD: n_state = ST_PV_CHK;
            ST_PV_CHK: begin
                if (i_stat.piv_zero) begin
                    n_sing  = 1'b1;
                    n_idx   = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_SC_ONE;
            end
            ST_SC_ONE: begin
                n_k     = '0;
                n_state = ST_SC_RD;
            end
            ST_SC_RD:  n_state = ST_SC_MUL;
            ST_SC_MUL: n_state = ST_SC_RND;
            ST_SC_RND: n_state = ST_SC_WR;
            ST_SC_WR: begin
                if (r_k == LAST_RC) begin
                    n_j     = '0;
                    n_state = ST_EL_F;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_SC_RD;
                end
            end
            ST_EL_F: begin
                if (r_j == i_pcol) begin
                    if (r_j == LAST_RC) n_state = ST_PASS_END;
                    else n_j = r_j + 1'b1;
                end else begin
                    n_state = ST_EL_Z;
                end
            end
            ST_EL_Z: begin
                n_k     = '0;
                n_state = ST_EL_RD;
            end
            ST_EL_RD:  n_state = ST_EL_MUL;
            ST_EL_MUL: n_state = ST_EL_RND;
            ST_EL_RND: n_state = ST_EL_WR;
            ST_EL_WR: begin
                if (r_k == LAST_RC) begin
                    if (r_j == LAST_RC) begin
                        n_state = ST_PASS_END;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EL_F;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_EL_RD;
                end
            end
            ST_PASS_END: begin
                if (r_pass == LAST_RC) begin
                    n_state = ST_UN_CHK;
                end else begin
                    n_pass  = r_pass + 1'b1;
                    n_state = ST_SR_CLR;
                end
            end
            ST_UN_CHK: begin
                n_k     = '0;
                n_state = (w_ua != w_ub) ? ST_UN_RD : ST_UN_NEXT;
            end
            ST_UN_RD: n_state = ST_UN_W1;
            ST_UN_W1: n_state = ST_UN_W2;
            ST_UN_W2: begin
                if (r_k == LAST_RC) begin
                    n_state = ST_UN_NEXT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_UN_RD;
                end
            end
            ST_UN_NEXT: begin
                if (r_pass == '0) begin
                    n_idx   = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_pass  = r_pass - 1'b1;
                    n_state = ST_UN_CHK;
                end
            end
            ST_OUT_RD: n_state = ST_OUT_SHOW;
            ST_OUT_SHOW: begin
                if (!i_stall) begin
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.wr_sel = WS_ELEM;
        o_rd_addr_a = '0;
        o_rd_addr_b = '0;
        o_wr_addr   = '0;
        o_srch_row  = r_j;
        o_srch_col  = r_k;
        o_stall     = (r_state != ST_LOAD);
        o_valid     = (r_state == ST_OUT_SHOW);
        o_singular  = r_sing;
        o_last      = (r_idx == LAST_IDX);
        case (r_state)
            ST_LOAD: begin
                o_cmd.wr_en = i_valid;
                o_wr_addr   = r_idx;
            end
            ST_SR_CLR: o_cmd.srch_clr = 1'b1;
            ST_SR_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.srch_en = !r_used[r_j] && !r_used[r_k];
                o_rd_addr_a   = f_addr(r_j, r_k);
            end
            ST_SW_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr_a = f_addr(i_prow, r_k);
                o_rd_addr_b = f_addr(i_pcol, r_k);
            end
            ST_SW_W1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RDB;
                o_wr_addr    = f_addr(i_prow, r_k);
            end
            ST_SW_W2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RDA;
                o_wr_addr    = f_addr(i_pcol, r_k);
            end
            ST_PV_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr_a = f_addr(i_pcol, i_pcol);
            end
            ST_PV_CHK: o_cmd.div_start = !i_stat.piv_zero;
            ST_SC_ONE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_ONE;
                o_wr_addr    = f_addr(i_pcol, i_pcol);
            end
            ST_SC_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr_a = f_addr(i_pcol, r_k);
            end
            ST_SC_MUL: o_cmd.mul_en = 1'b1;
            ST_SC_RND: o_cmd.rnd_en = 1'b1;
            ST_SC_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_PROD;
                o_wr_addr    = f_addr(i_pcol, r_k);
            end
            ST_EL_F: begin
                o_cmd.rd_en = (r_j != i_pcol);
                o_rd_addr_a = f_addr(r_j, i_pcol);
            end
            ST_EL_Z: begin
                o_cmd.fac_ld = 1'b1;
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_ZERO;
                o_wr_addr    = f_addr(r_j, i_pcol);
            end
            ST_EL_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr_a = f_addr(i_pcol, r_k);
                o_rd_addr_b = f_addr(r_j, r_k);
            end
            ST_EL_MUL: o_cmd.mul_en = 1'b1;
            ST_EL_RND: o_cmd.rnd_en = 1'b1;
            ST_EL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_DIFF;
                o_wr_addr    = f_addr(r_j, r_k);
            end
            ST_UN_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr_a = f_addr(r_k, w_ua);
                o_rd_addr_b = f_addr(r_k, w_ub);
            end
            ST_UN_W1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RDB;
                o_wr_addr    = f_addr(r_k, w_ua);
            end
            ST_UN_W2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RDA;
                o_wr_addr    = f_addr(r_k, w_ub);
            end
            ST_OUT_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr_a = r_idx;
            end
            default: o_cmd.rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_idx   <= '0;
            r_pass  <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_used  <= '0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
            r_j     <= n_j;
            r_k     <= n_k;
            r_used  <= n_used;
            r_sing  <= n_sing;
        end
        r_rec_row <= n_rec_row;
        r_rec_col <= n_rec_col;
    end

endmodule

// ----- sv/gauss_jordan_inverse_3x3.sv -----
// Operation: after the last element is taken, each pivot pass runs the serial
// reciprocal and then the read, multiply, round and write sequence per matrix
// element; the column unswaps follow before the first result.
// Throughput: nine elements in at one a cycle; nine results out, each read and
// then shown; a new matrix is taken once the last result has been taken.
// Reset: synchronous, active low; the block then waits for the first element.
// ----------------------------------------------------------------------------
// Gauss-Jordan matrix inverse
// Inverts a signed Q16.16 matrix by full-pivoting Gauss-Jordan elimination.
// ----------------------------------------------------------------------------
module gauss_jordan_inverse_3x3
    import gji_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [DW-1:0] i_element,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [DW-1:0] o_inverse_element,
    output logic                 o_singular,
    output logic                 o_last
);

    localparam int AW = $clog2(DIM * DIM);
    localparam int IW = $clog2(DIM);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [AW-1:0] w_rd_addr_a, w_rd_addr_b, w_wr_addr;
    logic [IW-1:0] w_srch_row, w_srch_col, w_prow, w_pcol;

    gji_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall     (i_stall),
        .i_stat      (w_stat),
        .i_prow      (w_prow),
        .i_pcol      (w_pcol),
        .o_cmd       (w_cmd),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .o_wr_addr   (w_wr_addr),
        .o_srch_row  (w_srch_row),
        .o_srch_col  (w_srch_col),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_singular  (o_singular),
        .o_last      (o_last)
    );

    gji_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_rd_addr_a       (w_rd_addr_a),
        .i_rd_addr_b       (w_rd_addr_b),
        .i_wr_addr         (w_wr_addr),
        .i_srch_row        (w_srch_row),
        .i_srch_col        (w_srch_col),
        .i_element         (i_element),
        .i_singular        (o_singular),
        .o_stat            (w_stat),
        .o_prow            (w_prow),
        .o_pcol            (w_pcol),
        .o_inverse_element (o_inverse_element)
    );

`ifndef SYNTHESIS
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_inverse_element == '0)
        else $error("Singular result carries a non-zero element.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("Input taken while results are being delivered.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid && !o_stall)
        else $error("Block did not return to loading after the last transaction.");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix inverse testbench
// Streams 3x3 Q16.16 matrices into the Gauss-Jordan inverse and checks every
// inverse element, singular flag and last mark against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import gji_pkg::*;

    localparam int N = 9;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [DW-1:0] elem;
        logic                 sing;
        logic                 last;
    } t_inv_res;

    class inverse_scoreboard;
        longint     mat [N];
        int         n_loaded;
        t_inv_res   pending [$];
        int         errors;

        function new();
            n_loaded = 0;
            errors   = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint sign_sat(longint m, bit neg);
            if (neg) return (m > 64'sd2147483648) ? -64'sd2147483648 : -m;
            return (m > 64'sd2147483647) ? 64'sd2147483647 : m;
        endfunction

        function longint qmul(longint a, longint b);
            longint p;
            p = (mag(a) * mag(b) + 64'sd32768) >>> 16;
            return sign_sat(p, (a < 0) != (b < 0));
        endfunction

        function bit invert_matrix();
            bit     used [3];
            int     prow_rec [3];
            int     pcol_rec [3];
            int     prow, pcol;
            longint big, inv, t, f;
            for (int i = 0; i < 3; i++) used[i] = 0;
            for (int i = 0; i < 3; i++) begin
                prow = 0;
                pcol = 0;
                big  = 0;
                for (int j = 0; j < 3; j++) begin
                    if (used[j]) continue;
                    for (int k = 0; k < 3; k++) begin
                        if (!used[k] && mag(mat[j*3+k]) >= big) begin
                            big  = mag(mat[j*3+k]);
                            prow = j;
                            pcol = k;
                        end
                    end
                end
                used[pcol] = 1;
                if (prow != pcol) begin
                    for (int k = 0; k < 3; k++) begin
                        t = mat[prow*3+k];
                        mat[prow*3+k] = mat[pcol*3+k];
                        mat[pcol*3+k] = t;
                    end
                end
                prow_rec[i] = prow;
                pcol_rec[i] = pcol;
                if (mat[pcol*3+pcol] == 0) return 1;
                inv = sign_sat((64'sd1 <<< 32) / mag(mat[pcol*3+pcol]), mat[pcol*3+pcol] < 0);
                mat[pcol*3+pcol] = 65536;
                for (int k = 0; k < 3; k++) mat[pcol*3+k] = qmul(mat[pcol*3+k], inv);
                for (int j = 0; j < 3; j++) begin
                    if (j == pcol) continue;
                    f = mat[j*3+pcol];
                    mat[j*3+pcol] = 0;
                    for (int k = 0; k < 3; k++)
                        mat[j*3+k] = sat32(mat[j*3+k] - qmul(mat[pcol*3+k], f));
                end
            end
            for (int i = 2; i >= 0; i--) begin
                if (prow_rec[i] == pcol_rec[i]) continue;
                for (int k = 0; k < 3; k++) begin
                    t = mat[k*3+prow_rec[i]];
                    mat[k*3+prow_rec[i]] = mat[k*3+pcol_rec[i]];
                    mat[k*3+pcol_rec[i]] = t;
                end
            end
            return 0;
        endfunction

        function void note_element(logic signed [DW-1:0] e);
            bit       sing;
            t_inv_res r;
            mat[n_loaded] = e;
            n_loaded++;
            if (n_loaded < N) return;
            n_loaded = 0;
            sing = invert_matrix();
            for (int i = 0; i < N; i++) begin
                r.elem = sing ? '0 : DW'(mat[i]);
                r.sing = sing;
                r.last = (i == N - 1);
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic signed [DW-1:0] e, logic s, logic l);
            t_inv_res x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result elem=%h singular=%b last=%b", $time, e, s, l);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (e !== x.elem) begin
                $display("%0t: inverse_element expected %h actual %h", $time, x.elem, e);
                errors++;
            end
            if (s !== x.sing) begin
                $display("%0t: singular expected %b actual %b", $time, x.sing, s);
                errors++;
            end
            if (l !== x.last) begin
                $display("%0t: last expected %b actual %b", $time, x.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [DW-1:0] i_element;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [DW-1:0] o_inverse_element;
    logic                 o_singular;
    logic                 o_last;

    inverse_scoreboard sb;
    int  cycles;
    bit  sink_busy;
    bit  sender_gaps;

    gauss_jordan_inverse_3x3 dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_element         (i_element),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_inverse_element (o_inverse_element),
        .o_singular        (o_singular),
        .o_last            (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_inverse_element, o_singular, o_last);
    end

    // While sink_busy is set, the receiving side may stall before each transaction after the first.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (o_valid && !i_stall) begin
            stall_left <= sink_busy ? $urandom_range(0, 9) : 0;
            i_stall    <= sink_busy && ($urandom_range(0, 1) == 1);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_element(logic signed [DW-1:0] e);
        int gap;
        i_valid   <= 1'b1;
        i_element <= e;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_element(e);
        gap = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_matrix(logic signed [DW-1:0] m [N]);
        for (int i = 0; i < N; i++) send_element(m[i]);
    endtask

    function automatic logic signed [DW-1:0] rand_elem(int kind);
        case (kind)
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            3: return $signed($urandom_range(0, 8)) - 4;
            default: return ($urandom_range(0, 3) == 0) ? '0 : $signed($urandom);
        endcase
    endfunction

    initial begin
        logic signed [DW-1:0] m [N];
        int kind;
        sb          = new();
        cycles      = 0;
        sink_busy   = 1'b0;
        sender_gaps = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_element   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity, all zero, extremes, a row-swap case, a rounding-zero pivot and a general invertible matrix.
        m = '{QONE, 0, 0, 0, QONE, 0, 0, 0, QONE};
        send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        m = '{32'sh7FFF_FFFF, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
        send_matrix(m);
        m = '{0, QONE, 0, 0, 0, 2*QONE, -3*QONE, 0, 0};
        send_matrix(m);
        m = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
        send_matrix(m);
        m = '{QONE, 2*QONE, 3*QONE, 4*QONE, 5*QONE, 6*QONE, 7*QONE, 8*QONE, 10*QONE};
        send_matrix(m);

        // Hold off until every expected transaction has been taken.
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);

        sender_gaps = 1'b1;
        sink_busy   = 1'b1;
        for (int t = 0; t < 46; t++) begin
            sender_gaps = (t % 10) != 5;
            sink_busy   = (t % 10) != 7;
            kind = $urandom_range(0, 4);
            for (int i = 0; i < N; i++) m[i] = rand_elem(kind);
            send_matrix(m);
        end

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
